[design/gbrag_pkg.sv]
// Shared types and constants for the GB2312 glyph row address generator.
package gbrag_pkg;

	localparam int SCREEN_PIXELS_WIDE_DEF = 256;
	localparam int QUEUE_DEPTH_DEF        = 2;

	localparam int GLYPH_ROWS = 12;
	localparam int ROW_CNT_W  = 4;

	localparam int COLUMN_W = 8;
	localparam int ROW_W    = 16;
	localparam int ADDR_W   = 18;
	localparam int COLOR_W  = 16;
	localparam int BASE_W   = 14;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] LEAD_MIN     = 8'h80;
	localparam logic [7:0] GB_CELL_MIN  = 8'hA1;
	// first lead of the high area; its zones follow the nine low ones
	localparam logic [7:0] GB_ZONE2_LEAD = 8'hB0;
	// lead - 0xA7 is 9+(lead-0xB0), the zone of a high area lead
	localparam logic [7:0] GB_ZONE_BIAS = 8'hA7;
	localparam logic [6:0] GB_ZONE_CELLS = 7'd94;

	localparam logic [COLUMN_W-1:0] ASCII_ADVANCE = 8'd6;
	localparam logic [COLUMN_W-1:0] HANZI_ADVANCE = 8'd12;
	localparam logic [ROW_W-1:0]    LINE_ADVANCE  = 16'd12;

	localparam logic FONT_ASCII = 1'b0;
	localparam logic FONT_HANZI = 1'b1;

	localparam logic [2:0] REG_DRAW_COLOR = 3'd0;

	// one glyph to draw: base is the ASCII code or the hanzi glyph index
	typedef struct packed {
		logic                screen;
		logic                kind;
		logic [BASE_W-1:0]   base;
		logic [ROW_W-1:0]    row;
		logic [COLUMN_W-1:0] column;
	} job_t;

endpackage

[design/gbrag_fifo.sv]
// Small FIFO that carries glyph jobs from the classifier to the row sequencer.
module gbrag_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/gbrag_front.sv]
// Front end: per-screen cursors, byte classification and glyph job building.
module gbrag_front #(
	parameter int SCREEN_PIXELS_WIDE = gbrag_pkg::SCREEN_PIXELS_WIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_byte,
	input  logic              screen_select,
	input  logic              job_full,
	output logic              job_push,
	output gbrag_pkg::job_t   job
);
	localparam logic [8:0] ASCII_WRAP = 9'(SCREEN_PIXELS_WIDE - 6);
	localparam logic [8:0] HANZI_WRAP = 9'(SCREEN_PIXELS_WIDE - 12);

	logic [gbrag_pkg::COLUMN_W-1:0] col_q [2];
	logic [gbrag_pkg::ROW_W-1:0]    row_q [2];
	logic [7:0]                     lead_q [2];
	logic [1:0]                     pend_q;

	logic                           accept;
	logic                           pend;
	logic [7:0]                     lead;
	logic [gbrag_pkg::COLUMN_W-1:0] col;
	logic [gbrag_pkg::ROW_W-1:0]    row;
	logic                           is_hanzi;
	logic                           is_newline;
	logic                           is_ascii;
	logic                           is_lead;
	logic                           wrap;
	logic [gbrag_pkg::COLUMN_W-1:0] col_w;
	logic [gbrag_pkg::ROW_W-1:0]    row_w;
	logic [gbrag_pkg::COLUMN_W-1:0] col_next;
	logic [gbrag_pkg::ROW_W-1:0]    row_next;
	logic                           emit;
	logic [6:0]                     zone;
	logic [6:0]                     trail_idx;
	logic [gbrag_pkg::BASE_W-1:0]   glyph;

	assign in_stall = job_full;
	assign accept   = in_valid && !in_stall;

	assign pend = pend_q[screen_select];
	assign lead = lead_q[screen_select];
	assign col  = col_q[screen_select];
	assign row  = row_q[screen_select];

	always_comb begin
		is_hanzi   = pend;
		is_newline = !pend && (char_byte == gbrag_pkg::NEWLINE_BYTE);
		is_lead    = !pend && (char_byte >= gbrag_pkg::LEAD_MIN);
		is_ascii   = !pend && !is_newline && !is_lead;

		if (is_hanzi) begin
			wrap = ({1'b0, col} >= HANZI_WRAP);
		end else if (is_ascii) begin
			wrap = ({1'b0, col} >= ASCII_WRAP);
		end else begin
			wrap = 1'b0;
		end
		col_w = wrap ? '0 : col;
		row_w = wrap ? row + gbrag_pkg::LINE_ADVANCE : row;

		if (is_newline) begin
			col_next = '0;
			row_next = row + gbrag_pkg::LINE_ADVANCE;
		end else if (is_hanzi) begin
			col_next = col_w + gbrag_pkg::HANZI_ADVANCE;
			row_next = row_w;
		end else if (is_ascii) begin
			col_next = col_w + gbrag_pkg::ASCII_ADVANCE;
			row_next = row_w;
		end else begin
			col_next = col;
			row_next = row;
		end

		// codes with either half below 0xA1 are outside the font: advance only
		emit = is_ascii || (is_hanzi && (lead >= gbrag_pkg::GB_CELL_MIN)
			&& (char_byte >= gbrag_pkg::GB_CELL_MIN));

		// low area leads count from 0xA1, high area leads continue after nine zones
		zone      = (lead < gbrag_pkg::GB_ZONE2_LEAD) ? 7'(lead - gbrag_pkg::GB_CELL_MIN)
			: 7'(lead - gbrag_pkg::GB_ZONE_BIAS);
		trail_idx = 7'(char_byte - gbrag_pkg::GB_CELL_MIN);
		glyph     = gbrag_pkg::BASE_W'(zone) * gbrag_pkg::BASE_W'(gbrag_pkg::GB_ZONE_CELLS)
			+ gbrag_pkg::BASE_W'(trail_idx);

		job.screen = screen_select;
		job.kind   = is_hanzi ? gbrag_pkg::FONT_HANZI : gbrag_pkg::FONT_ASCII;
		job.base   = is_hanzi ? glyph : gbrag_pkg::BASE_W'(char_byte[6:0]);
		job.row    = row_w;
		job.column = col_w;
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0]  <= '0;
			col_q[1]  <= '0;
			row_q[0]  <= '0;
			row_q[1]  <= '0;
			lead_q[0] <= '0;
			lead_q[1] <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			col_q[screen_select] <= col_next;
			row_q[screen_select] <= row_next;
			if (is_lead) begin
				lead_q[screen_select] <= char_byte;
				pend_q[screen_select] <= 1'b1;
			end else begin
				pend_q[screen_select] <= 1'b0;
			end
		end
	end

endmodule

[design/gbrag_back.sv]
// Back end: steps through the twelve rows of a glyph job into an output register.
module gbrag_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  gbrag_pkg::job_t               job,
	output logic                          job_pop,
	input  logic [gbrag_pkg::COLOR_W-1:0] draw_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          target_screen,
	output logic                          font_kind,
	output logic [17:0]                   font_address,
	output logic [15:0]                   screen_row,
	output logic [7:0]                    screen_column,
	output logic [15:0]                   pixel_color,
	output logic                          last_row
);
	logic                            busy_q;
	logic [gbrag_pkg::ROW_CNT_W-1:0] cnt_q;
	logic [gbrag_pkg::ADDR_W-1:0]    addr_q;
	logic [gbrag_pkg::ROW_W-1:0]     row_q;
	logic [gbrag_pkg::COLUMN_W-1:0]  col_q;
	logic                            screen_q;
	logic                            kind_q;
	logic                            out_valid_q;

	logic                            advance;
	logic                            last;
	logic [gbrag_pkg::ADDR_W-1:0]    base_ext;
	logic [gbrag_pkg::ADDR_W-1:0]    addr_x12;
	logic [gbrag_pkg::ADDR_W-1:0]    addr_first;

	assign advance = busy_q && (!out_valid_q || !out_stall);
	assign last    = (cnt_q == gbrag_pkg::ROW_CNT_W'(gbrag_pkg::GLYPH_ROWS - 1));
	// next job loads as the last row of the current one leaves: no bubble
	assign job_pop = job_valid && (!busy_q || (advance && last));

	// ASCII rows are 1 byte (c*12), hanzi rows 2 bytes (glyph*24)
	assign base_ext   = gbrag_pkg::ADDR_W'(job.base);
	assign addr_x12   = (base_ext << 3) + (base_ext << 2);
	assign addr_first = (job.kind == gbrag_pkg::FONT_HANZI) ? (addr_x12 << 1) : addr_x12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (advance) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			addr_q   <= addr_first;
			row_q    <= job.row;
			col_q    <= job.column;
			screen_q <= job.screen;
			kind_q   <= job.kind;
		end else if (advance) begin
			addr_q <= addr_q + ((kind_q == gbrag_pkg::FONT_HANZI) ? 18'd2 : 18'd1);
			row_q  <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_screen <= screen_q;
			font_kind     <= kind_q;
			font_address  <= addr_q;
			screen_row    <= row_q;
			screen_column <= col_q;
			pixel_color   <= draw_color;
			last_row      <= last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/gb2312_glyph_row_address_generator_unit.sv]
// Top level of the GB2312 glyph row address generator: config port, front, queue, back.
//
// Text bytes for two screens go in one a cycle while the job queue has room; each
// screen keeps its own cursor and pending lead byte. A newline, a held lead byte or
// a GB2312 code outside the font gives no beat. A drawn ASCII character or hanzi
// gives twelve row beats, one a cycle from the row sequencer while the output is not
// stalled; consecutive glyphs follow with no gap. Register 0 (byte address 0) holds
// the 16-bit draw color, reset 0xFFFF; write it only while no beat is pending.
module gb2312_glyph_row_address_generator_unit #(
	parameter int SCREEN_PIXELS_WIDE = gbrag_pkg::SCREEN_PIXELS_WIDE_DEF,
	parameter int QUEUE_DEPTH        = gbrag_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        screen_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        target_screen,
	output logic        font_kind,
	output logic [17:0] font_address,
	output logic [15:0] screen_row,
	output logic [7:0]  screen_column,
	output logic [15:0] pixel_color,
	output logic        last_row
);
	logic [gbrag_pkg::COLOR_W-1:0] draw_color_q;
	logic                          reg_hit;
	logic                          job_push;
	logic                          job_full;
	logic                          job_pop;
	logic                          job_valid;
	gbrag_pkg::job_t               job_in;
	gbrag_pkg::job_t               job_out;

	assign pready  = 1'b1;
	assign reg_hit = ({paddr[2], 2'b00} == gbrag_pkg::REG_DRAW_COLOR);
	assign prdata  = reg_hit ? {16'd0, draw_color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= 16'hFFFF;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			draw_color_q <= pwdata[15:0];
		end
	end

	gbrag_front #(
		.SCREEN_PIXELS_WIDE(SCREEN_PIXELS_WIDE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_byte    (char_byte),
		.screen_select(screen_select),
		.job_full     (job_full),
		.job_push     (job_push),
		.job          (job_in)
	);

	gbrag_fifo #(
		.WIDTH($bits(gbrag_pkg::job_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_valid(job_valid),
		.rd_data (job_out)
	);

	gbrag_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job_out),
		.job_pop      (job_pop),
		.draw_color   (draw_color_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_screen(target_screen),
		.font_kind    (font_kind),
		.font_address (font_address),
		.screen_row   (screen_row),
		.screen_column(screen_column),
		.pixel_color  (pixel_color),
		.last_row     (last_row)
	);

endmodule
